@@ rtl/running_upper_quartile_cutoff_defines.svh @@
// assertion macros for the upper quartile cutoff block
`ifndef RUNNING_UPPER_QUARTILE_CUTOFF_DEFINES_SVH
`define RUNNING_UPPER_QUARTILE_CUTOFF_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RUQC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ruqc check failed");

// next-cycle implication outside reset
`define RUQC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ruqc check failed");

`endif

@@ rtl/ruqc_pkg.sv @@
// shared types and codes for the upper quartile cutoff block
package ruqc_pkg;

    typedef enum logic {
        OP_QUERY  = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    // heap selector for the shared sift engine
    typedef enum logic {
        HEAP_LOWER = 1'b0,
        HEAP_UPPER = 1'b1
    } heap_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT_RD,
        ST_DECIDE,
        ST_POP_ROOT,
        ST_POP_LAST,
        ST_POP_VAL,
        ST_POP_CHILD,
        ST_POP_RIGHT,
        ST_POP_CMP,
        ST_PUSH_PAR,
        ST_PUSH_CMP,
        ST_NEXT_OP,
        ST_RESULT
    } state_t;

    // what the engine does after the current pop or push
    typedef enum logic [2:0] {
        SEQ_DONE,
        SEQ_PUSH_MOVED_LOWER,
        SEQ_PUSH_SCORE_UPPER,
        SEQ_BALANCE,
        SEQ_PUSH_MOVED_UPPER
    } seq_t;

endpackage

@@ rtl/running_upper_quartile_cutoff.sv @@
// upper quartile cutoff: two heaps in block memories with a shared sift engine
//
//  channel  signals                                        carries
//  in       in_valid in_stall op score                     request to block
//  out      out_valid out_stall cutoff cutoff_valid ...    result of a query
//
// a query holds in_stall through its root read and until its result is registered
// an insert runs up to two root pops and three pushes, each sifting one heap level
// at a time; no new request is taken until the last of them is done
// an insert into full stores is dropped in its accepting cycle and sets the flag
// reset clears counts and flag; heap entries are not reset, and a root read from an empty heap is never used
// a result waiting on out_stall holds only a later query, in its last cycle
module running_upper_quartile_cutoff
    import ruqc_pkg::*;
#(
    parameter int TOTAL_CAPACITY = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic signed [31:0] score,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] cutoff,
    output logic        cutoff_valid,
    output logic        overflowed
);

    localparam int UPPER_DEPTH = TOTAL_CAPACITY / 4 + 1;
    localparam int LAW = $clog2(TOTAL_CAPACITY);
    localparam int UAW = $clog2(UPPER_DEPTH);
    localparam int CW  = LAW + 1;
    localparam int IW  = LAW + 2;

    logic signed [31:0] lower_mem [TOTAL_CAPACITY];
    logic signed [31:0] upper_mem [UPPER_DEPTH];

    state_t state_reg, state_next;
    seq_t   seq_reg, seq_next;
    heap_sel_t heap_reg, heap_next;
    logic [CW-1:0] lcnt_reg, lcnt_next, ucnt_reg, ucnt_next;
    logic ovf_reg, ovf_next;
    logic signed [31:0] score_reg, score_next;
    logic signed [31:0] moved_reg, moved_next;
    logic signed [31:0] val_reg, val_next;     // entry being sifted
    logic signed [31:0] lchild_reg, lchild_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] n_reg, n_next;              // heap size during pop
    logic out_valid_reg, out_valid_next;
    logic signed [31:0] cutoff_reg, cutoff_next;
    logic cvalid_reg, cvalid_next;
    logic ovf_out_reg, ovf_out_next;

    // memory port controls
    logic rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic signed [31:0] wr_data, rd_data, lrd_q, urd_q;
    heap_sel_t rd_heap_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en && heap_reg == HEAP_LOWER)
        begin
            lrd_q <= lower_mem[rd_addr[LAW-1:0]];
        end
        if (rd_en && heap_reg == HEAP_UPPER)
        begin
            urd_q <= upper_mem[rd_addr[UAW-1:0]];
        end
        if (wr_en && heap_reg == HEAP_LOWER)
        begin
            lower_mem[wr_addr[LAW-1:0]] <= wr_data;
        end
        if (wr_en && heap_reg == HEAP_UPPER)
        begin
            upper_mem[wr_addr[UAW-1:0]] <= wr_data;
        end
        rd_heap_reg <= heap_reg;
    end

    assign rd_data = (rd_heap_reg == HEAP_LOWER) ? lrd_q : urd_q;

    // ordering: a above b in the current heap
    function automatic logic above(heap_sel_t h, logic signed [31:0] a,
                                   logic signed [31:0] b);
        above = (h == HEAP_LOWER) ? (a > b) : (a < b);
    endfunction

    logic [CW:0] total;
    logic [IW-1:0] lidx, ridx, pidx;
    logic accept, is_query, is_full, to_lower, balance_pop, out_busy;
    logic has_right, take_right, child_wins;
    logic signed [31:0] child_val;
    logic [IW-1:0] child_idx;

    assign total = {1'b0, lcnt_reg} + {1'b0, ucnt_reg};
    assign lidx = {idx_reg[IW-2:0], 1'b1};
    assign ridx = lidx + IW'(1);
    assign pidx = (idx_reg - IW'(1)) >> 1;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_busy = out_valid_reg && out_stall;
    assign is_query = (op_t'(op) == OP_QUERY);
    assign is_full = (total >= (CW+1)'(TOTAL_CAPACITY));
    assign to_lower = (total < (CW+1)'(4)) || (ucnt_reg == '0) || (score_reg < rd_data);
    assign balance_pop = (total[1:0] == 2'b00) && (lcnt_reg != '0);

    // sift-down choice: right child only when in range and strictly better
    assign has_right = (ridx < n_reg);
    assign take_right = has_right && above(heap_reg, rd_data, lchild_reg);
    assign child_val = take_right ? rd_data : lchild_reg;
    assign child_idx = take_right ? ridx : lidx;
    assign child_wins = above(heap_reg, child_val, val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seq_reg       <= SEQ_DONE;
            heap_reg      <= HEAP_LOWER;
            lcnt_reg      <= '0;
            ucnt_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            heap_reg      <= heap_next;
            lcnt_reg      <= lcnt_next;
            ucnt_reg      <= ucnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg  <= score_next;
        moved_reg  <= moved_next;
        val_reg    <= val_next;
        lchild_reg <= lchild_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        cutoff_reg <= cutoff_next;
        cvalid_reg <= cvalid_next;
        ovf_out_reg <= ovf_out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (is_query || !is_full))
                begin
                    state_next = ST_ROOT_RD;
                end
            end
            ST_ROOT_RD:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (seq_reg == SEQ_DONE)
                begin
                    state_next = ST_RESULT;
                end
                else if (to_lower)
                begin
                    state_next = ST_PUSH_PAR;
                end
                else
                begin
                    state_next = ST_POP_LAST;
                end
            end
            ST_POP_ROOT:  state_next = ST_POP_LAST;
            ST_POP_LAST:  state_next = ST_POP_VAL;
            ST_POP_VAL:   state_next = ST_POP_CHILD;
            ST_POP_CHILD:
            begin
                if (lidx >= n_reg)
                begin
                    state_next = ST_NEXT_OP;
                end
                else
                begin
                    state_next = ST_POP_RIGHT;
                end
            end
            ST_POP_RIGHT: state_next = ST_POP_CMP;
            ST_POP_CMP:
            begin
                if (child_wins)
                begin
                    state_next = ST_POP_CHILD;
                end
                else
                begin
                    state_next = ST_NEXT_OP;
                end
            end
            ST_PUSH_PAR:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_NEXT_OP;
                end
                else
                begin
                    state_next = ST_PUSH_CMP;
                end
            end
            ST_PUSH_CMP:
            begin
                if (above(heap_reg, val_reg, rd_data))
                begin
                    state_next = ST_PUSH_PAR;
                end
                else
                begin
                    state_next = ST_NEXT_OP;
                end
            end
            ST_NEXT_OP:
            begin
                if (seq_reg inside {SEQ_PUSH_MOVED_LOWER, SEQ_PUSH_SCORE_UPPER,
                                    SEQ_PUSH_MOVED_UPPER})
                begin
                    state_next = ST_PUSH_PAR;
                end
                else if (seq_reg == SEQ_BALANCE && balance_pop)
                begin
                    state_next = ST_POP_ROOT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        seq_next = seq_reg;
        heap_next = heap_reg;
        lcnt_next = lcnt_reg;
        ucnt_next = ucnt_reg;
        ovf_next = ovf_reg;
        score_next = score_reg;
        moved_next = moved_reg;
        val_next = val_reg;
        lchild_next = lchild_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        cutoff_next = cutoff_reg;
        cvalid_next = cvalid_reg;
        ovf_out_next = ovf_out_reg;
        out_valid_next = out_busy;
        rd_en = 1'b0;
        wr_en = 1'b0;
        rd_addr = '0;
        wr_addr = '0;
        wr_data = val_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    score_next = score;
                    heap_next = HEAP_UPPER;
                    if (is_query)
                    begin
                        seq_next = SEQ_DONE;
                    end
                    else if (is_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        seq_next = SEQ_BALANCE;
                    end
                end
            end
            ST_ROOT_RD:
            begin
                rd_en = 1'b1;
                rd_addr = '0;
            end
            ST_DECIDE:
            begin
                if (seq_reg == SEQ_DONE)
                begin
                    // keep the upper root until the result register is free
                    val_next = rd_data;
                end
                else if (to_lower)
                begin
                    // score straight into lower heap
                    heap_next = HEAP_LOWER;
                    val_next = score_reg;
                    idx_next = IW'(lcnt_reg);
                    lcnt_next = lcnt_reg + CW'(1);
                end
                else
                begin
                    // pop the upper root, already read
                    moved_next = rd_data;
                    seq_next = SEQ_PUSH_MOVED_LOWER;
                    n_next = IW'(ucnt_reg) - IW'(1);
                    ucnt_next = ucnt_reg - CW'(1);
                end
            end
            ST_POP_ROOT:
            begin
                rd_en = 1'b1;
                rd_addr = '0;
            end
            ST_POP_LAST:
            begin
                moved_next = rd_data;
                rd_en = 1'b1;
                rd_addr = n_reg;
            end
            ST_POP_VAL:
            begin
                val_next = rd_data;
                idx_next = '0;
            end
            ST_POP_CHILD:
            begin
                if (lidx >= n_reg)
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = lidx;
                end
            end
            ST_POP_RIGHT:
            begin
                lchild_next = rd_data;
                if (has_right)
                begin
                    rd_en = 1'b1;
                    rd_addr = ridx;
                end
            end
            ST_POP_CMP:
            begin
                wr_en = 1'b1;
                wr_addr = idx_reg;
                if (child_wins)
                begin
                    wr_data = child_val;
                    idx_next = child_idx;
                end
            end
            ST_PUSH_PAR:
            begin
                if (idx_reg == '0)
                begin
                    wr_en = 1'b1;
                    wr_addr = '0;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = pidx;
                end
            end
            ST_PUSH_CMP:
            begin
                wr_en = 1'b1;
                wr_addr = idx_reg;
                if (above(heap_reg, val_reg, rd_data))
                begin
                    wr_data = rd_data;
                    idx_next = pidx;
                end
            end
            ST_NEXT_OP:
            begin
                unique case (seq_reg)
                    SEQ_PUSH_MOVED_LOWER:
                    begin
                        heap_next = HEAP_LOWER;
                        val_next = moved_reg;
                        idx_next = IW'(lcnt_reg);
                        lcnt_next = lcnt_reg + CW'(1);
                        seq_next = SEQ_PUSH_SCORE_UPPER;
                    end
                    SEQ_PUSH_SCORE_UPPER:
                    begin
                        heap_next = HEAP_UPPER;
                        val_next = score_reg;
                        idx_next = IW'(ucnt_reg);
                        ucnt_next = ucnt_reg + CW'(1);
                        seq_next = SEQ_BALANCE;
                    end
                    SEQ_PUSH_MOVED_UPPER:
                    begin
                        heap_next = HEAP_UPPER;
                        val_next = moved_reg;
                        idx_next = IW'(ucnt_reg);
                        ucnt_next = ucnt_reg + CW'(1);
                        seq_next = SEQ_DONE;
                    end
                    SEQ_BALANCE:
                    begin
                        if (balance_pop)
                        begin
                            // move the lower root across
                            heap_next = HEAP_LOWER;
                            n_next = IW'(lcnt_reg) - IW'(1);
                            lcnt_next = lcnt_reg - CW'(1);
                            seq_next = SEQ_PUSH_MOVED_UPPER;
                        end
                        else
                        begin
                            seq_next = SEQ_DONE;
                        end
                    end
                    default: seq_next = SEQ_DONE;
                endcase
            end
            ST_RESULT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    cvalid_next = ucnt_reg != '0;
                    cutoff_next = (ucnt_reg != '0) ? val_reg : 32'sd0;
                    ovf_out_next = ovf_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign cutoff = cutoff_reg;
    assign cutoff_valid = cvalid_reg;
    assign overflowed = ovf_out_reg;

endmodule

@@ rtl/ruqc_checker.sv @@
// port-level checks for the upper quartile cutoff block
`include "running_upper_quartile_cutoff_defines.svh"
module ruqc_checker
    import ruqc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic signed [31:0] cutoff,
    input logic        cutoff_valid,
    input logic        overflowed
);

    `RUQC_ASSERT(a_zero_when_empty, out_valid && !cutoff_valid, cutoff == 32'sd0)
    `RUQC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cutoff))
    `RUQC_ASSERT_NEXT(a_sticky, out_valid && overflowed && !out_stall, !out_valid || overflowed)
    `RUQC_ASSERT_NEXT(a_flags_hold, out_valid && out_stall, $stable(cutoff_valid) && $stable(overflowed))

endmodule

bind running_upper_quartile_cutoff ruqc_checker u_ruqc_checker (.*);
